@@ design/fdf_pkg.sv @@
// ----------------------------------------------------------------------------
// fdf_pkg: shared types and microcode for the decimating FIR filter
// Holds the word types, the fixed arithmetic constants and the control store.
// ----------------------------------------------------------------------------
`default_nettype none

package fdf_pkg;

   typedef logic signed [15:0] word_type;
   typedef logic [1:0]         mode_type;
   typedef logic [7:0]         index_type;

   // Mode register codes.
   localparam mode_type MODE_PASS = 2'd0;
   localparam mode_type MODE_FIR  = 2'd1;
   localparam mode_type MODE_DEC  = 2'd2;

   // Input operation codes.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   // Fixed-point constants.
   localparam int SAMPLE_BITS = 10;
   localparam int SCALE_SHIFT = 6;
   localparam int OUT_SHIFT   = 5;
   localparam logic [2:0] DECIM_LAST = 3'd4;

   // Sequencer step addresses.
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type S_WAIT    = 4'd0;
   localparam step_type S_OP      = 4'd1;
   localparam step_type S_PUSH    = 4'd2;
   localparam step_type S_PHASE   = 4'd3;
   localparam step_type S_CLR     = 4'd4;
   localparam step_type S_MAC     = 4'd5;
   localparam step_type S_DRAIN1  = 4'd6;
   localparam step_type S_DRAIN2  = 4'd7;
   localparam step_type S_FIR_OUT = 4'd8;
   localparam step_type S_PASS    = 4'd9;
   localparam step_type S_COEF    = 4'd10;

   // Branch conditions.
   typedef logic [2:0] cond_type;

   localparam cond_type C_ALWAYS   = 3'd0;
   localparam cond_type C_NO_REQ   = 3'd1;
   localparam cond_type C_IS_COEF  = 3'd2;
   localparam cond_type C_MODE_PAS = 3'd3;
   localparam cond_type C_SKIP     = 3'd4;
   localparam cond_type C_MORE     = 3'd5;
   localparam cond_type C_OUT_BUSY = 3'd6;

   // One control word: the next step is tgt when the condition holds, else nxt.
   typedef struct packed {
      cond_type cond;
      step_type tgt;
      step_type nxt;
      logic     latch;
      logic     push;
      logic     phase;
      logic     clr;
      logic     issue;
      logic     emit;
      logic     emit_fir;
      logic     coef_wr;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      w.cond = C_ALWAYS;
      w.tgt  = S_WAIT;
      w.nxt  = S_WAIT;
      unique case (step)
         S_WAIT: begin
            w.cond  = C_NO_REQ;
            w.tgt   = S_WAIT;
            w.nxt   = S_OP;
            w.latch = 1'b1;
         end
         S_OP: begin
            w.cond = C_IS_COEF;
            w.tgt  = S_COEF;
            w.nxt  = S_PUSH;
         end
         S_PUSH: begin
            w.cond = C_MODE_PAS;
            w.tgt  = S_PASS;
            w.nxt  = S_PHASE;
            w.push = 1'b1;
         end
         S_PHASE: begin
            w.cond  = C_SKIP;
            w.tgt   = S_WAIT;
            w.nxt   = S_CLR;
            w.phase = 1'b1;
         end
         S_CLR: begin
            w.tgt = S_MAC;
            w.clr = 1'b1;
         end
         S_MAC: begin
            w.cond  = C_MORE;
            w.tgt   = S_MAC;
            w.nxt   = S_DRAIN1;
            w.issue = 1'b1;
         end
         S_DRAIN1: begin
            w.tgt = S_DRAIN2;
         end
         S_DRAIN2: begin
            w.tgt = S_FIR_OUT;
         end
         S_FIR_OUT: begin
            w.cond     = C_OUT_BUSY;
            w.tgt      = S_FIR_OUT;
            w.nxt      = S_WAIT;
            w.emit     = 1'b1;
            w.emit_fir = 1'b1;
         end
         S_PASS: begin
            w.cond = C_OUT_BUSY;
            w.tgt  = S_PASS;
            w.nxt  = S_WAIT;
            w.emit = 1'b1;
         end
         S_COEF: begin
            w.tgt     = S_WAIT;
            w.coef_wr = 1'b1;
         end
         default: begin
            w.tgt = S_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ design/fir_decimating_filter_top.sv @@
// The block takes no new input word until it is through with the last one. Each filtered
// sample comes from the single shared multiply-accumulate that walks the coefficient and
// delay memories one tap a cycle.
// Reset (synchronous, active high) sets mode 0, decimation phase 0 and an empty delay line
// through a fill count; coefficients hold nothing defined until written.
// ----------------------------------------------------------------------------
// fir_decimating_filter_top: microcoded decimating FIR filter
// A small control store sequences one multiply-accumulate over TAPS taps.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_decimating_filter_top #(
   parameter int TAPS = 256
) (
   input  wire                 clock,
   input  wire                 reset,
   // Input words: a sample push or a coefficient write.
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire                 req_op,
   input  fdf_pkg::word_type   req_sample,
   input  fdf_pkg::index_type  req_coef_index,
   input  fdf_pkg::word_type   req_coef_value,
   // Result words.
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output fdf_pkg::word_type   rsp_filtered,
   // Mode register write.
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  fdf_pkg::mode_type   csr_mode
);

   import fdf_pkg::*;

   // Address width of both memories and width of the fill count, which must
   // be able to hold TAPS itself.
   localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int FW = $clog2(TAPS + 1);

   localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
   localparam logic [FW-1:0] FULL      = FW'(TAPS);

   // ------------------------------------------------------------------
   // Sequencer: the step counter addresses the control store, and each
   // control word names one branch condition and two successor steps.
   // ------------------------------------------------------------------
   step_type  pc_ff, pc_in;
   ucode_type uw;
   logic      cond_true;

   // Latched input word. These are payload registers and need no reset.
   logic      op_ff;
   word_type  sample_ff;
   index_type coef_idx_ff;
   word_type  coef_val_ff;

   // Control state.
   mode_type        mode_ff;
   logic [2:0]      phase_ff;
   logic [AW-1:0]   wr_ptr_ff;
   logic [FW-1:0]   fill_ff;

   // Tap walk: k addresses the coefficient, rp the matching delay entry.
   logic [AW-1:0]   k_ff;
   logic [AW-1:0]   rp_ff;

   // Memories and their registered read data.
   word_type        coef_mem [TAPS];
   word_type        delay_mem [TAPS];
   word_type        coef_rd_ff;
   word_type        dl_rd_ff;
   logic            tap_ok_ff;
   logic            rd_vld_ff;

   // Multiply stage and accumulator.
   logic [SAMPLE_BITS-1:0] tap_bits;
   word_type               tap_val;
   logic signed [31:0]     product;
   word_type               prod_ff;
   logic                   mul_vld_ff;
   word_type               acc_ff;

   // Output register.
   logic      rsp_valid_ff;
   word_type  rsp_data_ff;
   logic      out_busy;
   logic      emit_go;
   logic      accept;
   logic      coef_in_range;

   assign uw        = ucode_rom(pc_ff);
   assign req_ready = uw.latch;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // A finished result holds the output register until the consumer takes it.
   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign emit_go  = uw.emit && !out_busy;

   // Coefficient indexes at or beyond the table depth are dropped.
   assign coef_in_range = (int'(coef_idx_ff) < TAPS);

   always_comb begin
      unique case (uw.cond)
         C_ALWAYS:   cond_true = 1'b1;
         C_NO_REQ:   cond_true = !accept;
         C_IS_COEF:  cond_true = (op_ff == OP_COEF);
         C_MODE_PAS: cond_true = (mode_ff == MODE_PASS);
         // In the decimating modes only the fifth sample goes on to filter.
         C_SKIP:     cond_true = mode_ff[1] && (phase_ff < DECIM_LAST);
         C_MORE:     cond_true = (k_ff != LAST_ADDR);
         C_OUT_BUSY: cond_true = out_busy;
         default:    cond_true = 1'b1;
      endcase
      pc_in = cond_true ? uw.tgt : uw.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         sample_ff   <= req_sample;
         coef_idx_ff <= req_coef_index;
         coef_val_ff <= req_coef_value;
      end
   end

   // ------------------------------------------------------------------
   // Mode register and decimation phase. A mode write always restarts
   // the decimation count.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PASS;
         phase_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         mode_ff  <= csr_mode;
         phase_ff <= '0;
      end else if (uw.phase && mode_ff[1]) begin
         phase_ff <= (phase_ff >= DECIM_LAST) ? 3'd0 : phase_ff + 3'd1;
      end
   end

   // ------------------------------------------------------------------
   // Delay line bookkeeping. The write pointer advances before each push,
   // and the fill count tells which taps already hold a real sample; the
   // rest read as zero, which is the cleared line after reset.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else if (uw.push) begin
         wr_ptr_ff <= (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + 1'b1;
         if (fill_ff != FULL) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (uw.push) begin
         delay_mem[(wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + 1'b1] <= sample_ff;
      end
      dl_rd_ff <= delay_mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (uw.coef_wr && coef_in_range) begin
         coef_mem[AW'(coef_idx_ff)] <= coef_val_ff;
      end
      coef_rd_ff <= coef_mem[k_ff];
   end

   // ------------------------------------------------------------------
   // Tap walk. Tap k pairs coefficient k with the sample pushed k words
   // ago, so the delay address walks backward from the newest entry.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (uw.clr) begin
         k_ff  <= '0;
         rp_ff <= wr_ptr_ff;
      end else if (uw.issue) begin
         k_ff  <= k_ff + 1'b1;
         rp_ff <= (rp_ff == '0) ? LAST_ADDR : rp_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      tap_ok_ff <= (FW'(k_ff) < fill_ff);
   end

   // ------------------------------------------------------------------
   // Multiply-accumulate pipeline: memory read, product, accumulate.
   // The tap value is the low sample bits as a signed number scaled by 64;
   // the upper half of the product is the arithmetic shift by 16.
   // ------------------------------------------------------------------
   assign tap_bits = tap_ok_ff ? dl_rd_ff[SAMPLE_BITS-1:0] : '0;
   assign tap_val  = {tap_bits, {SCALE_SHIFT{1'b0}}};
   assign product  = coef_rd_ff * tap_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= uw.issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= product[31:16];
      if (uw.clr) begin
         acc_ff <= '0;
      end else if (mul_vld_ff) begin
         // The accumulator wraps at 16 bits.
         acc_ff <= acc_ff + prod_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output register. Filter results are the accumulator shifted right
   // arithmetically by five; passthrough returns the whole sample word.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_data_ff <= uw.emit_fir ? (acc_ff >>> OUT_SHIFT) : sample_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_data_ff;

endmodule

`default_nettype wire

@@ design/fdf_checker.sv @@
// ----------------------------------------------------------------------------
// fdf_checker: port-level checks for the decimating FIR filter
// Watches the handshakes of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module fdf_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input fdf_pkg::word_type  rsp_filtered,
   input wire                csr_valid,
   input wire                csr_ready
);

   import fdf_pkg::*;

   word_type last_rsp;
   assign last_rsp = rsp_filtered;

   // A waiting result word holds steady until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(last_rsp))
      else $error("result word changed or dropped while stalled");

   // Reset empties the output register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One word at a time: the cycle after an accept the block is busy.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted in two consecutive cycles");

   // A result is loaded only by an output step, never while waiting for input.
   a_rsp_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the sequencer was idle");

   // The mode register is always writable.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("mode write stalled");

endmodule

bind fir_decimating_filter_top fdf_checker u_fdf_checker (.*);

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fir_decimating_filter_top
// Drives sample and coefficient words through valid/ready handshakes, tracks
// the filter state in a bit-accurate predictor and compares every result
// word against it, under several mode settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fdf_pkg::*;

   localparam int FILTER_TAPS = 256;
   // Mode 3 has no package name; the high bit alone selects decimation.
   localparam mode_type MODE_DEC_ALIAS = 2'd3;
   // Cycles to let a coefficient write or a dropped sample finish before a mode write.
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SEGMENT_WORDS = 64;

   // Clock, reset and block ports.
   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid;
   logic       req_ready;
   logic       req_op;
   word_type   req_sample;
   index_type  req_coef_index;
   word_type   req_coef_value;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   word_type   rsp_filtered;
   logic       csr_valid;
   logic       csr_ready;
   mode_type   csr_mode;

   // Predictor state: sample history, coefficient table, mode and decimation count.
   logic [15:0] sample_history [FILTER_TAPS];
   logic [15:0] coef_table [FILTER_TAPS];
   logic [7:0]  history_head;
   mode_type    cur_mode;
   logic [2:0]  decim_count;

   // Filtered words the block still owes us, oldest first.
   word_type    pending_filtered [$];

   int send_gap_pct;
   int ready_stall_pct;
   int mismatch_count;
   int cycle_count;

   fir_decimating_filter_top #(
      .TAPS(FILTER_TAPS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_sample(req_sample),
      .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_filtered(rsp_filtered),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_mode(csr_mode)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog: if the run has not ended by the limit, something hung.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("fir_decimating_filter_top verification failed");
      $finish;
   end

   // Walk all taps the way the hardware does: each tap value is the low 10 bits of the
   // stored sample taken as signed and scaled by 64; each product is floored by 2^16
   // and added into a 16-bit accumulator that wraps; the output drops 5 more bits.
   function automatic word_type fir_response();
      logic [15:0]        acc;
      logic [7:0]         pos;
      logic signed [15:0] scaled;
      logic signed [31:0] prod;
      word_type           result;
      acc = '0;
      for (int k = 0; k < FILTER_TAPS; k++) begin
         pos = history_head - 8'(k);
         scaled = {sample_history[pos][9:0], 6'b0};
         prod = $signed(coef_table[k]) * scaled;
         // Bits 31:16 are the product shifted right arithmetically by 16, wrapped.
         acc = acc + prod[31:16];
      end
      result = $signed(acc) >>> OUT_SHIFT;
      return result;
   endfunction

   // Apply one accepted word to the predicted state and queue any result it causes.
   function automatic void filter_step(input logic op, input word_type sample,
                                       input index_type idx, input word_type value);
      if (op == OP_COEF) begin
         coef_table[idx] = value;
         return;
      end
      history_head = history_head + 8'd1;
      sample_history[history_head] = sample;
      if (cur_mode == MODE_PASS) begin
         pending_filtered.push_back(sample);
      end else if (cur_mode == MODE_FIR) begin
         pending_filtered.push_back(fir_response());
      end else if (decim_count >= DECIM_LAST) begin
         decim_count = '0;
         pending_filtered.push_back(fir_response());
      end else begin
         decim_count = decim_count + 3'd1;
      end
   endfunction

   // Random sample word; about a third of them carry an extreme, minus one or zero in the low 10 bits.
   function automatic word_type pick_sample();
      word_type w;
      w = 16'($urandom_range(16'hFFFF, 0));
      if ($urandom_range(9) < 3) begin
         case ($urandom_range(3))
            0: begin
               w[9:0] = 10'h200;
            end
            1: begin
               w[9:0] = 10'h1FF;
            end
            2: begin
               w[9:0] = 10'h3FF;
            end
            default: begin
               w[9:0] = 10'h000;
            end
         endcase
      end
      return w;
   endfunction

   // Random coefficient; a few are the signed extremes, minus one or zero.
   function automatic word_type pick_coef();
      word_type w;
      w = 16'($urandom_range(16'hFFFF, 0));
      if ($urandom_range(9) < 2) begin
         case ($urandom_range(3))
            0: begin
               w = 16'h8000;
            end
            1: begin
               w = 16'h7FFF;
            end
            2: begin
               w = 16'hFFFF;
            end
            default: begin
               w = 16'h0000;
            end
         endcase
      end
      return w;
   endfunction

   // Send one word on the input channel. It is entered right after a rising edge. If a
   // gap is chosen, valid drops for a random gap first; otherwise the word follows the
   // previous one back to back with valid left high. The predictor sees the word once
   // the handshake completes.
   task automatic send_word(input logic op, input word_type sample,
                            input index_type idx, input word_type value);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_gap_pct) begin
         gap = $urandom_range(4, 1);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_sample     <= sample;
      req_coef_index <= idx;
      req_coef_value <= value;
      do @(posedge clock); while (!req_ready);
      filter_step(op, sample, idx, value);
   endtask

   // Sample word with random filler in the unused coefficient fields.
   task automatic send_sample(input word_type sample);
      send_word(OP_SAMPLE, sample, 8'($urandom_range(255)),
                16'($urandom_range(16'hFFFF, 0)));
   endtask

   // Coefficient word with random filler in the unused sample field.
   task automatic send_coef(input index_type idx, input word_type value);
      send_word(OP_COEF, 16'($urandom_range(16'hFFFF, 0)), idx, value);
   endtask

   // The mode register is only written while the block is idle: every owed result
   // has come back, and a last coefficient write or dropped sample has had time to
   // retire. Any mode write also restarts the decimation count.
   task automatic write_mode(input mode_type value);
      req_valid <= 1'b0;
      while (pending_filtered.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_mode  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_mode = value;
      decim_count = '0;
   endtask

   // Result side: every accepted word is checked against the oldest owed value, and
   // ready is redrawn each cycle from the current stall rate.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_filtered.size() == 0) begin
               $display("%0t: unexpected result word, expected none actual %h",
                        $time, rsp_filtered);
               mismatch_count++;
            end else begin
               if (rsp_filtered !== pending_filtered[0]) begin
                  $display("%0t: filtered mismatch, expected %h actual %h",
                           $time, pending_filtered[0], rsp_filtered);
                  mismatch_count++;
               end
               void'(pending_filtered.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= ready_stall_pct);
      end
   end

   // In passthrough mode the whole sample word comes back, upper bits included.
   task automatic test_passthrough();
      send_sample(16'h0000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'hFFFF);
      send_sample(16'h0200);
      send_sample(16'hA5FF);
   endtask

   // Every tap must hold a written coefficient before any filtering. The first taps
   // get the signed extremes, and the last index is written too.
   task automatic test_coef_load();
      send_coef(8'd0, 16'h8000);
      send_coef(8'd1, 16'h7FFF);
      for (int k = 2; k < FILTER_TAPS; k++) begin
         send_coef(8'(k), pick_coef());
      end
      send_coef(8'd255, 16'hFFFF);
   endtask

   // Filter on every sample. A low field of 0x200 is the most negative tap value, and
   // against the most negative coefficient it gives the largest product. Upper sample
   // bits must not matter, and a coefficient write in this mode produces nothing.
   task automatic test_fir_extremes();
      write_mode(MODE_FIR);
      send_sample(16'h0200);
      send_sample(16'hFE00);
      send_sample(16'h01FF);
      send_coef(8'd2, 16'h8000);
      send_sample(16'h03FF);
      send_sample(16'h0000);
   endtask

   // Decimation: one result per five samples. A mode write part way through the
   // count must restart it, and mode 3 must decimate exactly like mode 2.
   task automatic test_decimation();
      write_mode(MODE_DEC);
      repeat (7) send_sample(pick_sample());
      write_mode(MODE_DEC);
      repeat (5) send_sample(pick_sample());
      write_mode(MODE_DEC_ALIAS);
      repeat (5) send_sample(pick_sample());
   endtask

   // Random traffic in each idle pattern and each mode: mostly samples with a
   // sprinkling of coefficient rewrites.
   task automatic test_random_traffic();
      mode_type modes [4];
      int send_pct [4];
      int stall_pct [4];
      modes = '{MODE_PASS, MODE_FIR, MODE_DEC, MODE_DEC_ALIAS};
      send_pct = '{0, 54, 0, 10};
      stall_pct = '{0, 0, 54, 10};
      for (int p = 0; p < 4; p++) begin
         for (int m = 0; m < 4; m++) begin
            write_mode(modes[m]);
            send_gap_pct = send_pct[p];
            ready_stall_pct = stall_pct[p];
            repeat (SEGMENT_WORDS) begin
               if ($urandom_range(99) < 12) begin
                  send_coef(8'($urandom_range(255)), pick_coef());
               end else begin
                  send_sample(pick_sample());
               end
            end
         end
      end
   endtask

   initial begin
      req_valid      <= 1'b0;
      req_op         <= OP_SAMPLE;
      req_sample     <= '0;
      req_coef_index <= '0;
      req_coef_value <= '0;
      csr_valid      <= 1'b0;
      csr_mode       <= MODE_PASS;
      send_gap_pct    = 0;
      ready_stall_pct = 0;
      mismatch_count  = 0;
      // Predictor reset: empty history, passthrough mode, count at zero.
      for (int k = 0; k < FILTER_TAPS; k++) begin
         sample_history[k] = '0;
         coef_table[k] = '0;
      end
      history_head = '0;
      cur_mode = MODE_PASS;
      decim_count = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The directed part runs with modest idling so the handshakes are exercised early.
      send_gap_pct = 20;
      ready_stall_pct = 20;
      test_passthrough();
      test_coef_load();
      test_fir_extremes();
      test_decimation();
      test_random_traffic();

      // Drain: wait for every owed word, then give the block time to show a stray one.
      req_valid <= 1'b0;
      while (pending_filtered.size() != 0) @(posedge clock);
      repeat (FILTER_TAPS + 16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("fir_decimating_filter_top verification clean");
      end else begin
         $display("fir_decimating_filter_top verification failed");
      end
      $finish;
   end

endmodule
